@@ hw/rtl/lhm_pkg.sv @@
package lhm_pkg;

   // Field and register widths
   localparam int unsigned TimeWidth = 32;
   localparam int unsigned CsrIndexWidth = 3;
   localparam int unsigned ReqDataWidth = 96;
   localparam int unsigned RspDataWidth = 112;

   // Sample interval used when the register holds zero
   localparam logic [TimeWidth-1:0] DefaultInterval = 32'd500;

   // Register indexes
   localparam logic [CsrIndexWidth-1:0] CSR_SAMPLE_INTERVAL = 3'd0;
   localparam logic [CsrIndexWidth-1:0] CSR_ERROR_WINDOW    = 3'd1;
   localparam logic [CsrIndexWidth-1:0] CSR_ERROR_BURST     = 3'd2;
   localparam logic [CsrIndexWidth-1:0] CSR_RECV_WARN_LIMIT = 3'd3;
   localparam logic [CsrIndexWidth-1:0] CSR_RECV_LOST_LIMIT = 3'd4;
   localparam logic [CsrIndexWidth-1:0] CSR_RECOVERY_HOLD   = 3'd5;
   localparam logic [CsrIndexWidth-1:0] CSR_STATUS_REPEAT   = 3'd6;
   localparam logic [CsrIndexWidth-1:0] CSR_STATUS_ENABLE   = 3'd7;

   // Link state codes as they appear on the result
   localparam logic [1:0] CODE_HEALTHY  = 2'd0;
   localparam logic [1:0] CODE_DEGRADED = 2'd1;
   localparam logic [1:0] CODE_LOST     = 2'd2;

   // Severity codes
   localparam logic [1:0] LVL_NOTICE   = 2'd0;
   localparam logic [1:0] LVL_WARNING  = 2'd1;
   localparam logic [1:0] LVL_CRITICAL = 2'd2;

   // Reason codes
   localparam logic [2:0] RSN_NONE      = 3'd0;
   localparam logic [2:0] RSN_RECV_LOST = 3'd1;
   localparam logic [2:0] RSN_RECV_WARN = 3'd2;
   localparam logic [2:0] RSN_ERR_BURST = 3'd3;
   localparam logic [2:0] RSN_RECOVERED = 3'd4;

   // Request mode
   localparam logic MODE_TICK  = 1'b0;
   localparam logic MODE_START = 1'b1;

   typedef enum logic [2:0] {
      LS_HEALTHY  = 3'b001,
      LS_DEGRADED = 3'b010,
      LS_LOST     = 3'b100
   } link_type;

   typedef struct packed {
      logic [TimeWidth-1:0] sample_interval;
      logic [TimeWidth-1:0] error_window;
      logic [TimeWidth-1:0] error_burst;
      logic [TimeWidth-1:0] recv_warn_limit;
      logic [TimeWidth-1:0] recv_lost_limit;
      logic [TimeWidth-1:0] recovery_hold;
      logic [TimeWidth-1:0] status_repeat;
      logic                 status_enable;
   } cfg_type;

   typedef struct packed {
      logic                 mode;
      logic [TimeWidth-1:0] now_ms;
      logic [TimeWidth-1:0] send_error_total;
      logic [TimeWidth-1:0] recv_time_ms;
   } req_type;

   typedef struct packed {
      logic                 sampled;
      logic [1:0]           link_state;
      logic [1:0]           previous_state;
      logic                 state_changed;
      logic                 status_emitted;
      logic [1:0]           severity;
      logic [2:0]           reason_code;
      logic [TimeWidth-1:0] since_recv_ms;
      logic [TimeWidth-1:0] errors_in_window;
      logic [TimeWidth-1:0] last_change_ms;
   } rsp_type;

   function automatic logic [1:0] state_code(input link_type st);
      logic [1:0] code;
      case (st)
         LS_HEALTHY:  code = CODE_HEALTHY;
         LS_DEGRADED: code = CODE_DEGRADED;
         LS_LOST:     code = CODE_LOST;
         default:     code = CODE_HEALTHY;
      endcase
      return code;
   endfunction

endpackage

@@ hw/rtl/lhm_csr.sv @@
module lhm_csr (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [lhm_pkg::CsrIndexWidth-1:0]    csr_index,
   input  logic [lhm_pkg::TimeWidth-1:0]        csr_data,
   output lhm_pkg::cfg_type                     cfg
);
   import lhm_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   // Decode the write into the addressed register
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_SAMPLE_INTERVAL: cfg_in.sample_interval = csr_data;
            CSR_ERROR_WINDOW:    cfg_in.error_window    = csr_data;
            CSR_ERROR_BURST:     cfg_in.error_burst     = csr_data;
            CSR_RECV_WARN_LIMIT: cfg_in.recv_warn_limit = csr_data;
            CSR_RECV_LOST_LIMIT: cfg_in.recv_lost_limit = csr_data;
            CSR_RECOVERY_HOLD:   cfg_in.recovery_hold   = csr_data;
            CSR_STATUS_REPEAT:   cfg_in.status_repeat   = csr_data;
            CSR_STATUS_ENABLE:   cfg_in.status_enable   = csr_data[0];
            default:             cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.sample_interval <= 32'd500;
         cfg_ff.error_window    <= 32'd1000;
         cfg_ff.error_burst     <= 32'd5;
         cfg_ff.recv_warn_limit <= 32'd1500;
         cfg_ff.recv_lost_limit <= 32'd5000;
         cfg_ff.recovery_hold   <= 32'd2000;
         cfg_ff.status_repeat   <= 32'd5000;
         cfg_ff.status_enable   <= 1'b1;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

@@ hw/rtl/lhm_core.sv @@
module lhm_core (
   input  logic             clock,
   input  logic             reset,
   input  logic             advance,
   input  lhm_pkg::req_type req,
   input  lhm_pkg::cfg_type cfg,
   output lhm_pkg::rsp_type rsp
);
   import lhm_pkg::*;

   localparam logic [TimeWidth-1:0] AllOnes = {TimeWidth{1'b1}};

   link_type             state_ff, state_in;
   logic [TimeWidth-1:0] last_sample_ff, last_sample_in;
   logic [TimeWidth-1:0] last_change_ff, last_change_in;
   logic [TimeWidth-1:0] last_status_ff, last_status_in;
   logic [TimeWidth-1:0] healthy_start_ff, healthy_start_in;
   logic [TimeWidth-1:0] prev_total_ff, prev_total_in;
   logic [TimeWidth-1:0] win_start_ff, win_start_in;
   logic [TimeWidth-1:0] win_count_ff, win_count_in;
   logic                 sample_vld_ff, sample_vld_in;
   logic                 status_vld_ff, status_vld_in;
   logic                 healthy_vld_ff, healthy_vld_in;

   logic [TimeWidth-1:0] interval;
   logic                 gated;
   logic [TimeWidth-1:0] err_delta;
   logic [TimeWidth:0]   err_sum;
   logic [TimeWidth-1:0] count_added;
   logic [TimeWidth-1:0] count_new;
   logic [TimeWidth-1:0] recv_base;
   logic [TimeWidth-1:0] since;
   link_type             want;
   logic [2:0]           want_reason;
   logic [TimeWidth-1:0] hs_eff;
   logic                 recover;
   logic                 emit_ok_changed;
   logic                 emit_ok_steady;

   // Gate ticks to the sample interval
   assign interval = (cfg.sample_interval == '0) ? DefaultInterval : cfg.sample_interval;
   assign gated    = sample_vld_ff && ((req.now_ms - last_sample_ff) < interval);

   // Count new send errors, saturating, then restart an expired window
   assign err_delta   = req.send_error_total - prev_total_ff;
   assign err_sum     = {1'b0, win_count_ff} + {1'b0, err_delta};
   assign count_added = (req.send_error_total > prev_total_ff)
                        ? (err_sum[TimeWidth] ? AllOnes : err_sum[TimeWidth-1:0])
                        : win_count_ff;
   assign count_new   = ((req.now_ms - win_start_ff) > cfg.error_window) ? '0 : count_added;

   // Time since last receive, or since last change if never received
   assign recv_base = (req.recv_time_ms != '0) ? req.recv_time_ms : last_change_ff;
   assign since     = (req.now_ms > recv_base) ? (req.now_ms - recv_base) : '0;

   // Classify the link
   always_comb begin
      if (since > cfg.recv_lost_limit) begin
         want        = LS_LOST;
         want_reason = RSN_RECV_LOST;
      end else if (since > cfg.recv_warn_limit) begin
         want        = LS_DEGRADED;
         want_reason = RSN_RECV_WARN;
      end else if (count_new >= cfg.error_burst) begin
         want        = LS_DEGRADED;
         want_reason = RSN_ERR_BURST;
      end else begin
         want        = LS_HEALTHY;
         want_reason = RSN_NONE;
      end
   end

   // Recovery hold and emission rate limit
   assign hs_eff          = healthy_vld_ff ? healthy_start_ff : req.now_ms;
   assign recover         = (req.now_ms - hs_eff) >= cfg.recovery_hold;
   assign emit_ok_changed = cfg.status_enable;
   assign emit_ok_steady  = cfg.status_enable && (!status_vld_ff ||
                            ((req.now_ms - last_status_ff) >= cfg.status_repeat));

   // Next state and result
   always_comb begin
      state_in         = state_ff;
      last_sample_in   = last_sample_ff;
      last_change_in   = last_change_ff;
      last_status_in   = last_status_ff;
      healthy_start_in = healthy_start_ff;
      prev_total_in    = prev_total_ff;
      win_start_in     = win_start_ff;
      win_count_in     = win_count_ff;
      sample_vld_in    = sample_vld_ff;
      status_vld_in    = status_vld_ff;
      healthy_vld_in   = healthy_vld_ff;

      rsp.sampled        = 1'b0;
      rsp.state_changed  = 1'b0;
      rsp.status_emitted = 1'b0;
      rsp.severity       = LVL_NOTICE;
      rsp.reason_code    = RSN_NONE;
      rsp.since_recv_ms  = '0;

      if (req.mode == MODE_START) begin
         state_in         = LS_HEALTHY;
         sample_vld_in    = 1'b0;
         last_change_in   = req.now_ms;
         status_vld_in    = 1'b0;
         healthy_start_in = req.now_ms;
         healthy_vld_in   = 1'b1;
         prev_total_in    = '0;
         win_start_in     = req.now_ms;
         win_count_in     = '0;
      end else if (!gated) begin
         rsp.sampled       = 1'b1;
         rsp.since_recv_ms = since;
         rsp.reason_code   = want_reason;
         last_sample_in    = req.now_ms;
         sample_vld_in     = 1'b1;
         prev_total_in     = req.send_error_total;
         win_count_in      = count_new;
         if ((req.now_ms - win_start_ff) > cfg.error_window) begin
            win_start_in = req.now_ms;
         end

         if (want == LS_HEALTHY && state_ff != LS_HEALTHY) begin
            healthy_start_in = hs_eff;
            healthy_vld_in   = 1'b1;
            if (recover) begin
               state_in          = LS_HEALTHY;
               last_change_in    = req.now_ms;
               rsp.state_changed = 1'b1;
               rsp.reason_code   = RSN_RECOVERED;
               status_vld_in     = 1'b0;
               if (emit_ok_changed) begin
                  rsp.status_emitted = 1'b1;
                  last_status_in     = req.now_ms;
                  status_vld_in      = 1'b1;
               end
            end
         end else if (want != LS_HEALTHY) begin
            healthy_vld_in = 1'b0;
            if (want != state_ff) begin
               state_in          = want;
               last_change_in    = req.now_ms;
               rsp.state_changed = 1'b1;
               status_vld_in     = 1'b0;
            end
            if ((want != state_ff) ? emit_ok_changed : emit_ok_steady) begin
               rsp.status_emitted = 1'b1;
               rsp.severity       = (want == LS_LOST) ? LVL_CRITICAL : LVL_WARNING;
               last_status_in     = req.now_ms;
               status_vld_in      = 1'b1;
            end
         end else begin
            healthy_start_in = req.now_ms;
            healthy_vld_in   = 1'b1;
         end
      end

      rsp.link_state       = state_code(state_in);
      rsp.previous_state   = state_code(state_ff);
      rsp.errors_in_window = win_count_in;
      rsp.last_change_ms   = last_change_in;
   end

   // Commit state when the request moves to the result register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= LS_HEALTHY;
         last_sample_ff   <= '0;
         last_change_ff   <= '0;
         last_status_ff   <= '0;
         healthy_start_ff <= '0;
         prev_total_ff    <= '0;
         win_start_ff     <= '0;
         win_count_ff     <= '0;
         sample_vld_ff    <= 1'b0;
         status_vld_ff    <= 1'b0;
         healthy_vld_ff   <= 1'b0;
      end else if (advance) begin
         state_ff         <= state_in;
         last_sample_ff   <= last_sample_in;
         last_change_ff   <= last_change_in;
         last_status_ff   <= last_status_in;
         healthy_start_ff <= healthy_start_in;
         prev_total_ff    <= prev_total_in;
         win_start_ff     <= win_start_in;
         win_count_ff     <= win_count_in;
         sample_vld_ff    <= sample_vld_in;
         status_vld_ff    <= status_vld_in;
         healthy_vld_ff   <= healthy_vld_in;
      end
   end

endmodule

@@ hw/rtl/link_health_monitor.sv @@
// Channel  Direction  Ports                                   Content
// req      in         req_tvalid/tready/tdata/tuser           one tick or start request
// rsp      out        rsp_tvalid/tready/tdata                 one result per request
// csr      in         csr_valid/ready/index/data              register write
//
// Each request passes an input register and a result register, one request per
// cycle sustained while rsp_tready stays high. The state update sits in the
// single evaluation step between the two registers. Reset clears the valid
// flags and the monitor state and loads the register defaults. A stalled
// result holds its register; the input register still takes one request,
// after which req_tready follows rsp_tready. csr_ready is always high.
module link_health_monitor (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   // [31:0] now_ms, [63:32] send_error_total, [95:64] recv_time_ms
   input  logic [lhm_pkg::ReqDataWidth-1:0]     req_tdata,
   // [0] mode
   input  logic                                 req_tuser,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // [0] sampled, [2:1] link_state, [4:3] previous_state, [5] state_changed,
   // [6] status_emitted, [8:7] severity, [11:9] reason_code,
   // [43:12] since_recv_ms, [75:44] errors_in_window, [107:76] last_change_ms,
   // [111:108] zero
   output logic [lhm_pkg::RspDataWidth-1:0]     rsp_tdata,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [lhm_pkg::CsrIndexWidth-1:0]    csr_index,
   input  logic [lhm_pkg::TimeWidth-1:0]        csr_data
);
   import lhm_pkg::*;

   cfg_type cfg;
   req_type req_ff, req_in;
   rsp_type rsp_ff, rsp_comb;
   logic    in_vld_ff, in_vld_in;
   logic    out_vld_ff, out_vld_in;
   logic    advance;
   logic    take;

   lhm_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   lhm_core u_core (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .req     (req_ff),
      .cfg     (cfg),
      .rsp     (rsp_comb)
   );

   // Move a request forward when the result register is free or draining
   assign advance    = in_vld_ff && (!out_vld_ff || rsp_tready);
   assign req_tready = !in_vld_ff || advance;
   assign take       = req_tvalid && req_tready;

   assign in_vld_in  = take || (in_vld_ff && !advance);
   assign out_vld_in = advance || (out_vld_ff && !rsp_tready);

   always_comb begin
      req_in                  = req_ff;
      if (take) begin
         req_in.mode             = req_tuser;
         req_in.now_ms           = req_tdata[31:0];
         req_in.send_error_total = req_tdata[63:32];
         req_in.recv_time_ms     = req_tdata[95:64];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         in_vld_ff  <= in_vld_in;
         out_vld_ff <= out_vld_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      req_ff <= req_in;
      if (advance) begin
         rsp_ff <= rsp_comb;
      end
   end

   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata  = {4'd0,
                        rsp_ff.last_change_ms,
                        rsp_ff.errors_in_window,
                        rsp_ff.since_recv_ms,
                        rsp_ff.reason_code,
                        rsp_ff.severity,
                        rsp_ff.status_emitted,
                        rsp_ff.state_changed,
                        rsp_ff.previous_state,
                        rsp_ff.link_state,
                        rsp_ff.sampled};

endmodule

@@ tb/link_health_monitor_checker.sv @@
module link_health_monitor_checker (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   input  logic                              req_tready,
   input  logic [lhm_pkg::ReqDataWidth-1:0]  req_tdata,
   input  logic                              req_tuser,
   input  logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   input  logic [lhm_pkg::RspDataWidth-1:0]  rsp_tdata,
   input  logic                              csr_valid,
   input  logic                              csr_ready,
   input  logic [lhm_pkg::CsrIndexWidth-1:0] csr_index,
   input  logic [lhm_pkg::TimeWidth-1:0]     csr_data,
   output int                                mismatch_count,
   output int                                results_pending
);

   timeunit 1ns;
   timeprecision 1ps;

   import lhm_pkg::*;

   // Shadow copy of the registers
   cfg_type settings;

   // Shadow copy of the monitor state
   logic [1:0]           mon_state;
   logic [TimeWidth-1:0] sample_time;
   logic [TimeWidth-1:0] change_time;
   logic [TimeWidth-1:0] status_time;
   logic [TimeWidth-1:0] healthy_since;
   logic [TimeWidth-1:0] seen_total;
   logic [TimeWidth-1:0] window_start;
   logic [TimeWidth-1:0] window_count;
   logic                 sample_seen;
   logic                 status_seen;
   logic                 healthy_seen;

   // Link reports predicted but not yet seen on the result channel
   rsp_type link_reports_due[$];

   task automatic log_error(input string msg);
      $display("%0t ns: %s", $time, msg);
      mismatch_count++;
   endtask

   task automatic compare_field(input string name, input logic [TimeWidth-1:0] got,
                                input logic [TimeWidth-1:0] want);
      if (got !== want)
         log_error($sformatf("%s mismatch: got 0x%0h, expected 0x%0h", name, got, want));
   endtask

   // Grant a status emission unless disabled or repeated too soon
   function automatic bit grant_status(input logic [TimeWidth-1:0] now_ms);
      if (!settings.status_enable)
         return 1'b0;
      if (status_seen && (now_ms - status_time) < settings.status_repeat)
         return 1'b0;
      status_time = now_ms;
      status_seen = 1'b1;
      return 1'b1;
   endfunction

   // Advance the shadow monitor by one request and build its link report
   task automatic predict_link_status(input logic mode, input logic [TimeWidth-1:0] now_ms,
                                      input logic [TimeWidth-1:0] total,
                                      input logic [TimeWidth-1:0] recv_ms,
                                      output rsp_type r);
      logic [TimeWidth-1:0] interval;
      logic [TimeWidth-1:0] base;
      logic [TimeWidth-1:0] delta;
      logic [1:0]           want;
      r = '0;
      r.previous_state = mon_state;
      if (mode == MODE_START) begin
         mon_state = CODE_HEALTHY;
         sample_seen = 1'b0;
         change_time = now_ms;
         status_seen = 1'b0;
         healthy_since = now_ms;
         healthy_seen = 1'b1;
         seen_total = '0;
         window_start = now_ms;
         window_count = '0;
      end else begin
         interval = (settings.sample_interval == '0) ? DefaultInterval
                                                     : settings.sample_interval;
         if (!(sample_seen && (now_ms - sample_time) < interval)) begin
            want = CODE_HEALTHY;
            r.sampled = 1'b1;
            sample_time = now_ms;
            sample_seen = 1'b1;

            // Count new send errors, saturating; a falling total adds nothing
            if (total > seen_total) begin
               delta = total - seen_total;
               window_count = (window_count > ~delta) ? '1 : window_count + delta;
            end
            seen_total = total;
            if ((now_ms - window_start) > settings.error_window) begin
               window_start = now_ms;
               window_count = '0;
            end

            // Age of the last receive, or of the last change if none yet
            base = (recv_ms != '0) ? recv_ms : change_time;
            r.since_recv_ms = (now_ms > base) ? now_ms - base : '0;

            if (r.since_recv_ms > settings.recv_lost_limit) begin
               want = CODE_LOST;
               r.reason_code = RSN_RECV_LOST;
            end else if (r.since_recv_ms > settings.recv_warn_limit) begin
               want = CODE_DEGRADED;
               r.reason_code = RSN_RECV_WARN;
            end else if (window_count >= settings.error_burst) begin
               want = CODE_DEGRADED;
               r.reason_code = RSN_ERR_BURST;
            end

            if (want == CODE_HEALTHY && mon_state != CODE_HEALTHY) begin
               // Recover only after a continuous healthy hold
               if (!healthy_seen) begin
                  healthy_since = now_ms;
                  healthy_seen = 1'b1;
               end
               if ((now_ms - healthy_since) >= settings.recovery_hold) begin
                  mon_state = CODE_HEALTHY;
                  change_time = now_ms;
                  status_seen = 1'b0;
                  r.state_changed = 1'b1;
                  r.reason_code = RSN_RECOVERED;
                  if (grant_status(now_ms)) begin
                     r.status_emitted = 1'b1;
                     r.severity = LVL_NOTICE;
                  end
               end
            end else if (want != CODE_HEALTHY) begin
               healthy_seen = 1'b0;
               if (want != mon_state) begin
                  mon_state = want;
                  change_time = now_ms;
                  status_seen = 1'b0;
                  r.state_changed = 1'b1;
               end
               if (grant_status(now_ms)) begin
                  r.status_emitted = 1'b1;
                  r.severity = (want == CODE_LOST) ? LVL_CRITICAL : LVL_WARNING;
               end
            end else begin
               healthy_since = now_ms;
               healthy_seen = 1'b1;
            end
         end
      end
      r.link_state = mon_state;
      r.errors_in_window = window_count;
      r.last_change_ms = change_time;
   endtask

   initial begin
      mismatch_count = 0;
      results_pending = 0;
   end

   // Watch all three channels at each edge
   always @(posedge clock) begin
      rsp_type want;
      rsp_type got;
      if (reset) begin
         settings = '{sample_interval: 32'd500, error_window: 32'd1000, error_burst: 32'd5,
                      recv_warn_limit: 32'd1500, recv_lost_limit: 32'd5000,
                      recovery_hold: 32'd2000, status_repeat: 32'd5000,
                      status_enable: 1'b1};
         mon_state = CODE_HEALTHY;
         sample_time = '0;
         change_time = '0;
         status_time = '0;
         healthy_since = '0;
         seen_total = '0;
         window_start = '0;
         window_count = '0;
         sample_seen = 1'b0;
         status_seen = 1'b0;
         healthy_seen = 1'b0;
         link_reports_due.delete();
      end else begin
         // Track register writes
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_SAMPLE_INTERVAL: settings.sample_interval = csr_data;
               CSR_ERROR_WINDOW:    settings.error_window    = csr_data;
               CSR_ERROR_BURST:     settings.error_burst     = csr_data;
               CSR_RECV_WARN_LIMIT: settings.recv_warn_limit = csr_data;
               CSR_RECV_LOST_LIMIT: settings.recv_lost_limit = csr_data;
               CSR_RECOVERY_HOLD:   settings.recovery_hold   = csr_data;
               CSR_STATUS_REPEAT:   settings.status_repeat   = csr_data;
               CSR_STATUS_ENABLE:   settings.status_enable   = csr_data[0];
               default: ;
            endcase
         end

         // Compare each accepted result with the oldest link report due
         if (rsp_tvalid && rsp_tready) begin
            if (link_reports_due.size() == 0) begin
               log_error("result arrived with no request outstanding");
            end else begin
               want = link_reports_due.pop_front();
               got.sampled          = rsp_tdata[0];
               got.link_state       = rsp_tdata[2:1];
               got.previous_state   = rsp_tdata[4:3];
               got.state_changed    = rsp_tdata[5];
               got.status_emitted   = rsp_tdata[6];
               got.severity         = rsp_tdata[8:7];
               got.reason_code      = rsp_tdata[11:9];
               got.since_recv_ms    = rsp_tdata[43:12];
               got.errors_in_window = rsp_tdata[75:44];
               got.last_change_ms   = rsp_tdata[107:76];
               compare_field("sampled", TimeWidth'(got.sampled),
                             TimeWidth'(want.sampled));
               compare_field("link_state", TimeWidth'(got.link_state),
                             TimeWidth'(want.link_state));
               compare_field("previous_state", TimeWidth'(got.previous_state),
                             TimeWidth'(want.previous_state));
               compare_field("state_changed", TimeWidth'(got.state_changed),
                             TimeWidth'(want.state_changed));
               compare_field("status_emitted", TimeWidth'(got.status_emitted),
                             TimeWidth'(want.status_emitted));
               compare_field("severity", TimeWidth'(got.severity),
                             TimeWidth'(want.severity));
               compare_field("reason_code", TimeWidth'(got.reason_code),
                             TimeWidth'(want.reason_code));
               compare_field("since_recv_ms", got.since_recv_ms, want.since_recv_ms);
               compare_field("errors_in_window", got.errors_in_window,
                             want.errors_in_window);
               compare_field("last_change_ms", got.last_change_ms, want.last_change_ms);
            end
         end

         // Predict the report for each accepted request
         if (req_tvalid && req_tready) begin
            predict_link_status(req_tuser, req_tdata[31:0], req_tdata[63:32],
                                req_tdata[95:64], want);
            link_reports_due.push_back(want);
         end
      end
      results_pending <= link_reports_due.size();
   end

endmodule

@@ tb/link_health_monitor_test.sv @@
module link_health_monitor_test;

   timeunit 1ns;
   timeprecision 1ps;

   import lhm_pkg::*;

   logic                     clock = 1'b0;
   logic                     reset;
   logic                     req_tvalid;
   logic                     req_tready;
   // [31:0] now_ms, [63:32] send_error_total, [95:64] recv_time_ms
   logic [ReqDataWidth-1:0]  req_tdata;
   // [0] mode
   logic                     req_tuser;
   logic                     rsp_tvalid;
   logic                     rsp_tready;
   // [0] sampled, [2:1] link_state, [4:3] previous_state, [5] state_changed,
   // [6] status_emitted, [8:7] severity, [11:9] reason_code,
   // [43:12] since_recv_ms, [75:44] errors_in_window, [107:76] last_change_ms
   logic [RspDataWidth-1:0]  rsp_tdata;
   logic                     csr_valid;
   logic                     csr_ready;
   logic [CsrIndexWidth-1:0] csr_index;
   logic [TimeWidth-1:0]     csr_data;

   int mismatch_count;
   int results_pending;

   // Runs of back-to-back traffic on each side
   int req_calm = 0;
   int rsp_calm = 0;

   // Link time as seen by the request stream
   logic [TimeWidth-1:0] wall_ms = '0;

   link_health_monitor u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   link_health_monitor_checker u_checker (
      .clock           (clock),
      .reset           (reset),
      .req_tvalid      (req_tvalid),
      .req_tready      (req_tready),
      .req_tdata       (req_tdata),
      .req_tuser       (req_tuser),
      .rsp_tvalid      (rsp_tvalid),
      .rsp_tready      (rsp_tready),
      .rsp_tdata       (rsp_tdata),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_data        (csr_data),
      .mismatch_count  (mismatch_count),
      .results_pending (results_pending)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // Draw an idle count, with occasional runs of no idling
   function automatic int draw_wait(inout int calm);
      if (calm > 0) begin
         calm--;
         return 0;
      end
      if ($urandom_range(0, 15) == 0) begin
         calm = $urandom_range(10, 40);
         return 0;
      end
      return $urandom_range(0, 13);
   endfunction

   // Present one request and hold it until accepted
   task automatic send_request(input logic mode, input logic [TimeWidth-1:0] now_ms,
                               input logic [TimeWidth-1:0] total,
                               input logic [TimeWidth-1:0] recv_ms);
      int gap;
      gap = draw_wait(req_calm);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= mode;
      req_tdata <= {recv_ms, total, now_ms};
      do @(posedge clock); while (!req_tready);
   endtask

   // Drop valid and wait until every request has its result
   task automatic drain_results();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (results_pending != 0) @(posedge clock);
   endtask

   // Write one register, keeping valid high across back-to-back writes
   task automatic write_register(input logic [CsrIndexWidth-1:0] idx,
                                 input logic [TimeWidth-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
   endtask

   task automatic program_registers(input cfg_type s);
      write_register(CSR_SAMPLE_INTERVAL, s.sample_interval);
      write_register(CSR_ERROR_WINDOW, s.error_window);
      write_register(CSR_ERROR_BURST, s.error_burst);
      write_register(CSR_RECV_WARN_LIMIT, s.recv_warn_limit);
      write_register(CSR_RECV_LOST_LIMIT, s.recv_lost_limit);
      write_register(CSR_RECOVERY_HOLD, s.recovery_hold);
      write_register(CSR_STATUS_REPEAT, s.status_repeat);
      // upper bits are junk; only bit 0 counts
      write_register(CSR_STATUS_ENABLE, ($urandom & ~32'd1) | s.status_enable);
      csr_valid <= 1'b0;
   endtask

   // Register settings for each traffic phase
   function automatic cfg_type make_settings(input int which);
      cfg_type s;
      case (which)
         1: s = '{sample_interval: 32'd0, error_window: 32'd2000, error_burst: 32'd3,
                  recv_warn_limit: 32'd800, recv_lost_limit: 32'd2500,
                  recovery_hold: 32'd1000, status_repeat: 32'd1500, status_enable: 1'b1};
         2: s = '{sample_interval: 32'd1, error_window: 32'd50, error_burst: 32'd1,
                  recv_warn_limit: 32'd100, recv_lost_limit: 32'd300,
                  recovery_hold: 32'd200, status_repeat: 32'd0, status_enable: 1'b1};
         3: s = '{sample_interval: 32'd300, error_window: 32'd1000, error_burst: 32'd4,
                  recv_warn_limit: 32'd1000, recv_lost_limit: 32'd3000,
                  recovery_hold: 32'd1200, status_repeat: 32'd2000, status_enable: 1'b0};
         4: s = '{sample_interval: 32'd0, error_window: 32'd0, error_burst: 32'd0,
                  recv_warn_limit: 32'd0, recv_lost_limit: 32'd0,
                  recovery_hold: 32'd0, status_repeat: 32'd0, status_enable: 1'b1};
         5: s = '{sample_interval: '1, error_window: '1, error_burst: '1,
                  recv_warn_limit: '1, recv_lost_limit: '1,
                  recovery_hold: '1, status_repeat: '1, status_enable: 1'b1};
         6, 7: s = '{sample_interval: $urandom_range(0, 1500),
                     error_window: $urandom_range(0, 3000),
                     error_burst: $urandom_range(0, 12),
                     recv_warn_limit: $urandom_range(0, 3000),
                     recv_lost_limit: $urandom_range(0, 6000),
                     recovery_hold: $urandom_range(0, 3000),
                     status_repeat: $urandom_range(0, 4000),
                     status_enable: 1'($urandom_range(0, 1))};
         default: s = '{sample_interval: 32'd500, error_window: 32'd1000, error_burst: 32'd5,
                        recv_warn_limit: 32'd1500, recv_lost_limit: 32'd5000,
                        recovery_hold: 32'd2000, status_repeat: 32'd5000,
                        status_enable: 1'b1};
      endcase
      return s;
   endfunction

   // Mostly a plausible link history: a start, then ticks paced around the
   // sample interval while the link drops, recovers and sees error storms
   task automatic run_traffic(input cfg_type s, input int count);
      logic [TimeWidth-1:0] pace;
      logic [TimeWidth-1:0] reach;
      logic [TimeWidth-1:0] total;
      logic [TimeWidth-1:0] recv_ms;
      bit                   link_up;
      bit                   storm;
      int                   roll;
      int                   pick;
      pace = (s.sample_interval == '0) ? DefaultInterval : s.sample_interval;
      if (pace > 3000) pace = 3000;
      reach = s.recv_lost_limit;
      if (reach > 20000) reach = 20000;
      if (reach < 100) reach = 100;
      if ($urandom_range(0, 3) == 0) wall_ms = $urandom;
      link_up = 1'b1;
      storm = 1'b0;
      total = '0;
      recv_ms = wall_ms;
      send_request(MODE_START, wall_ms, total, recv_ms);
      for (int n = 1; n < count; n++) begin
         roll = $urandom_range(0, 99);
         if (roll < 8) begin
            // noise: any field, any value
            send_request(($urandom_range(0, 3) == 0) ? MODE_START : MODE_TICK,
                         $urandom, $urandom, $urandom);
         end else if (roll < 11) begin
            total = '0;
            send_request(MODE_START, wall_ms, total, recv_ms);
         end else begin
            if ($urandom_range(0, 24) == 0) link_up = !link_up;
            if ($urandom_range(0, 19) == 0) storm = !storm;
            wall_ms += ($urandom_range(0, 15) == 0) ? $urandom_range(0, 2 * reach)
                                                    : $urandom_range(0, 2 * pace);
            if (storm) total += $urandom_range(0, 6);
            else if ($urandom_range(0, 9) == 0) total += 1;
            if ($urandom_range(0, 49) == 0) total = $urandom_range(0, 10);
            pick = $urandom_range(0, 29);
            if (pick == 0) recv_ms = '0;
            else if (pick == 1) recv_ms = wall_ms + $urandom_range(1, 1000);
            else if (link_up) recv_ms = wall_ms - $urandom_range(0, pace);
            send_request(MODE_TICK, wall_ms, total, recv_ms);
         end
      end
   endtask

   // Result side: stall a random number of cycles before each result
   initial begin
      int stall;
      rsp_tready = 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         stall = draw_wait(rsp_calm);
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!(rsp_tvalid && rsp_tready));
      end
   end

   initial begin
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = MODE_TICK;
      csr_valid = 1'b0;
      csr_index = CSR_SAMPLE_INTERVAL;
      csr_data = '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Directed part under the reset settings
      // before any start the first tick is always evaluated
      send_request(MODE_TICK, 32'd0, 32'd0, 32'd0);
      send_request(MODE_START, 32'd1000, 32'd0, 32'd0);
      // first tick after the start is evaluated; the next comes too soon: gated
      send_request(MODE_TICK, 32'd1100, 32'd0, 32'd1050);
      send_request(MODE_TICK, 32'd1500, 32'd2, 32'd1400);
      send_request(MODE_TICK, 32'd1700, 32'd2, 32'd1600);
      // error jump comes too soon after the previous evaluation: gated
      send_request(MODE_TICK, 32'd2000, 32'd9, 32'd1900);
      // window expires: the error count restarts at zero, link stays healthy
      send_request(MODE_TICK, 32'd2600, 32'd9, 32'd2500);
      send_request(MODE_TICK, 32'd3200, 32'd9, 32'd3100);
      send_request(MODE_TICK, 32'd4700, 32'd9, 32'd4600);
      // receive goes stale: warn, repeat held back, then lost
      send_request(MODE_TICK, 32'd6300, 32'd9, 32'd4600);
      send_request(MODE_TICK, 32'd6900, 32'd9, 32'd4600);
      send_request(MODE_TICK, 32'd10000, 32'd9, 32'd4600);
      // receive time ahead of now
      send_request(MODE_TICK, 32'd10600, 32'd9, 32'd20000);
      // falling error total
      send_request(MODE_TICK, 32'd11200, 32'd3, 32'd11100);
      send_request(MODE_TICK, 32'd11700, 32'hFFFF_FFF0, 32'd11600);
      send_request(MODE_TICK, 32'd12200, 32'd0, 32'd12100);
      send_request(MODE_TICK, 32'd12500, 32'hFFFF_FFFF, 32'd12400);
      // time wraps past zero, with no receive time on most ticks
      send_request(MODE_START, 32'hFFFF_FE00, 32'd0, 32'd0);
      send_request(MODE_TICK, 32'h0000_0100, 32'd1, 32'd0);
      send_request(MODE_TICK, 32'h0000_1000, 32'd1, 32'hFFFF_FFFF);
      send_request(MODE_TICK, 32'h0000_2000, 32'd1, 32'd0);
      send_request(MODE_START, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);

      // Random phases, each with its own register settings
      for (int phase = 0; phase < 9; phase++) begin
         cfg_type s;
         drain_results();
         s = make_settings(phase);
         program_registers(s);
         run_traffic(s, 200);
      end

      drain_results();
      repeat (4) @(posedge clock);
      if (mismatch_count == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

   initial begin
      #5_000_000;
      $display("Simulation FAILED");
      $finish;
   end

endmodule

@@ sim.f @@
hw/rtl/lhm_pkg.sv
hw/rtl/lhm_csr.sv
hw/rtl/lhm_core.sv
hw/rtl/link_health_monitor.sv
tb/link_health_monitor_checker.sv
tb/link_health_monitor_test.sv
